### rtl/grid_period_rms_meter_top_macros.svh
// Assertion macros for the grid period RMS meter.
// Used by the top level; the including module supplies clk and rst.
`ifndef GRID_PERIOD_RMS_METER_TOP_MACROS_SVH
`define GRID_PERIOD_RMS_METER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gprm check failed");

// The consequent must hold in the cycle after the antecedent.
`define GPRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gprm check failed");

`endif

### rtl/gprm_pkg.sv
// Shared types, constants and helper functions of the grid period RMS meter.
// No dependencies; used by the channel interface users and all modules.
`timescale 1ns / 1ps

package gprm_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int RECIP_W = 21;
  localparam int RAD_W = 42;

  localparam logic [7:0] AVG_PERIODS_RST = 8'd25;

  localparam logic [7:0] REG_FREQ_COEFF = 8'd0;
  localparam logic [7:0] REG_AVG_PERIODS = 8'd1;

  localparam logic signed [32:0] W_02 = 33'sd209715;
  localparam logic signed [32:0] W_08 = 33'sd838860;
  localparam logic signed [32:0] W_04 = 33'sd419430;
  localparam logic signed [32:0] W_06 = 33'sd629145;
  localparam logic signed [32:0] W_07 = 33'sd734003;
  localparam logic signed [32:0] W_03 = 33'sd314572;

  typedef struct packed {
    logic signed [31:0] grid_voltage;
    logic signed [31:0] out_voltage;
    logic signed [31:0] pll_phase_step;
    logic               zero_cross;
  } in_word_t;

  typedef struct packed {
    logic [30:0]        grid_rms;
    logic [30:0]        out_rms;
    logic signed [31:0] grid_freq;
    logic signed [31:0] grid_mean;
    logic signed [31:0] out_mean;
    logic [15:0]        period_samples;
    logic               averaging_on;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [31:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    logic signed [31:0] r;
    if (x > 67'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [66:0] s;
    s = 67'(a) + 67'(b);
    return sat32(s);
  endfunction

endpackage

### rtl/gprm_chan_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// Depends on nothing; payload types come from gprm_pkg at instantiation.
`timescale 1ns / 1ps

interface gprm_chan_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/gprm_iter.sv
// Shared bit-serial unit: restoring divide of 2^20 by the sample count,
// or integer square root, one result bit per cycle. Uses gprm_pkg.
`timescale 1ns / 1ps

module gprm_iter #(
  parameter int CW = gprm_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gprm_pkg::iter_req_t            req,
  input  logic [CW-1:0]                  divisor,
  input  logic [gprm_pkg::RAD_W-1:0]     radicand,
  output gprm_pkg::iter_stat_t           stat,
  output logic [gprm_pkg::RECIP_W-1:0]   result
);
  import gprm_pkg::*;

  localparam int REM_W = 26;

  logic                busy;
  logic                done;
  logic                mode_sqrt;
  logic [4:0]          cnt;
  logic [RAD_W-1:0]    x;
  logic [REM_W-1:0]    rem;
  logic [RECIP_W-1:0]  q;
  logic [CW-1:0]       d;
  logic [REM_W-1:0]    shifted;
  logic [REM_W-1:0]    trial;
  logic [REM_W-1:0]    rem_next;
  logic [RECIP_W-1:0]  q_next;

  always_comb begin
    if (mode_sqrt) begin
      shifted = {rem[REM_W-3:0], x[RAD_W-1:RAD_W-2]};
      trial = REM_W'({q, 2'b01});
    end else begin
      shifted = {rem[REM_W-2:0], x[RAD_W-1]};
      trial = REM_W'(d);
    end
    if (shifted >= trial) begin
      rem_next = shifted - trial;
      q_next = {q[RECIP_W-2:0], 1'b1};
    end else begin
      rem_next = shifted;
      q_next = {q[RECIP_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'(RECIP_W - 1);
        mode_sqrt <= req.is_sqrt;
        x <= req.is_sqrt ? radicand : {1'b1, {(RAD_W-1){1'b0}}};
        rem <= '0;
        q <= '0;
        d <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        q <= q_next;
        x <= mode_sqrt ? {x[RAD_W-3:0], 2'b00} : {x[RAD_W-2:0], 1'b0};
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result = q;
endmodule

### rtl/grid_period_rms_meter_top.sv
// Top level of the grid period RMS meter: sequencer, shared multiplier,
// accumulators and filters. Uses gprm_pkg, gprm_chan_if and gprm_iter.
`timescale 1ns / 1ps

// One word is one sample of grid and output voltage with its PLL phase step.
// An ordinary sample passes ST_IDLE, ST_MUL_O, ST_MUL_F and ST_ACC. A sample
// that closes a grid period also takes a reciprocal of the count and one
// square root per RMS value, all through one bit-serial unit, and three
// passes of the one shared 33x33 multiplier per filtered value (the means
// too during start-up averaging). A square root is skipped when the mean
// square is not positive. The input is not ready meanwhile. A finished result
// waits in an output register, and the next sample is taken while it waits;
// the closing step of a later period waits for that result to leave.

module grid_period_rms_meter_top #(
  parameter int COUNTER_WIDTH = gprm_pkg::COUNTER_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  gprm_chan_if.sink   in_ch,
  gprm_chan_if.sink   cfg,
  gprm_chan_if.source out_ch
);
  import gprm_pkg::*;

  `include "grid_period_rms_meter_top_macros.svh"

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_MUL_O    = 14'b00000000000010,
    ST_MUL_F    = 14'b00000000000100,
    ST_ACC      = 14'b00000000001000,
    ST_DIV_GO   = 14'b00000000010000,
    ST_DIV_WAIT = 14'b00000000100000,
    ST_SCALE    = 14'b00000001000000,
    ST_NORM     = 14'b00000010000000,
    ST_SQ_GO    = 14'b00000100000000,
    ST_SQ_WAIT  = 14'b00001000000000,
    ST_OLD      = 14'b00010000000000,
    ST_NEW      = 14'b00100000000000,
    ST_SUM      = 14'b01000000000000,
    ST_FIN      = 14'b10000000000000
  } state_t;

  state_t state;

  logic [30:0]              freq_coeff;
  logic [7:0]               avg_periods;
  logic signed [31:0]       vo;
  logic signed [31:0]       step;
  logic                     zc;
  logic signed [31:0]       grid_square_sum;
  logic signed [31:0]       out_square_sum;
  logic signed [31:0]       freq_sum;
  logic signed [31:0]       grid_signal_sum;
  logic signed [31:0]       out_signal_sum;
  logic [COUNTER_WIDTH-1:0] sample_counter;
  logic signed [31:0]       fv [5];
  logic                     averaging_flag;
  logic [7:0]               avg_count;
  logic [7:0]               avg_count_next;
  logic [RECIP_W-1:0]       recip;
  logic [2:0]               job;
  logic signed [31:0]       nv;
  logic signed [32:0]       part;
  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [65:0]       prod;
  logic signed [31:0]       norm_val;
  logic signed [31:0]       fr_val;
  logic                     out_valid;
  out_word_t                out_word;
  logic                     fin_go;
  logic                     flag_next;

  iter_req_t          it_req;
  iter_stat_t         it_stat;
  logic [RECIP_W-1:0] it_result;

  gprm_iter #(.CW(COUNTER_WIDTH)) u_iter (
    .clk      (clk),
    .rst      (rst),
    .req      (it_req),
    .divisor  (sample_counter),
    .radicand ({1'b0, nv[30:0], 10'b0}),
    .stat     (it_stat),
    .result   (it_result)
  );

  assign it_req.start = (state == ST_DIV_GO) || (state == ST_SQ_GO);
  assign it_req.is_sqrt = (state == ST_SQ_GO);

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_word;

  always_comb begin
    mul_a = {in_ch.data.grid_voltage[31], in_ch.data.grid_voltage};
    mul_b = {in_ch.data.grid_voltage[31], in_ch.data.grid_voltage};
    unique case (state)
      ST_MUL_O: begin
        mul_a = {vo[31], vo};
        mul_b = {vo[31], vo};
      end
      ST_MUL_F: begin
        mul_a = {2'b00, freq_coeff};
        mul_b = {step[31], step};
      end
      ST_SCALE: begin
        mul_b = {12'b0, recip};
        case (job)
          3'd0: mul_a = {grid_signal_sum[31], grid_signal_sum};
          3'd1: mul_a = {out_signal_sum[31], out_signal_sum};
          3'd2: mul_a = {grid_square_sum[31], grid_square_sum};
          3'd3: mul_a = {out_square_sum[31], out_square_sum};
          default: mul_a = {freq_sum[31], freq_sum};
        endcase
      end
      ST_OLD: begin
        mul_a = {fv[job][31], fv[job]};
        case (job)
          3'd0, 3'd1: mul_b = W_07;
          3'd2, 3'd3: mul_b = W_02;
          default: mul_b = W_04;
        endcase
      end
      ST_NEW: begin
        mul_a = {nv[31], nv};
        case (job)
          3'd0, 3'd1: mul_b = W_03;
          3'd2, 3'd3: mul_b = W_08;
          default: mul_b = W_06;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (job)
      3'd0, 3'd1: norm_val = sat32(67'(prod >>> 20));
      3'd2, 3'd3: norm_val = sat32(67'(prod >>> 12));
      default: norm_val = sat32(67'(prod >>> 10));
    endcase
  end

  assign fr_val = sat32(67'(prod >>> 25));
  assign fin_go = !out_valid || out_ch.ready;
  assign avg_count_next = avg_count + 8'd1;
  assign flag_next = averaging_flag && (avg_count_next != avg_periods);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_coeff <= '0;
      avg_periods <= AVG_PERIODS_RST;
    end else if (cfg.valid) begin
      if (cfg.data.index == REG_FREQ_COEFF) begin
        freq_coeff <= cfg.data.value[30:0];
      end else if (cfg.data.index == REG_AVG_PERIODS) begin
        avg_periods <= cfg.data.value[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      grid_square_sum <= '0;
      out_square_sum <= '0;
      freq_sum <= '0;
      grid_signal_sum <= '0;
      out_signal_sum <= '0;
      sample_counter <= '0;
      for (int i = 0; i < 5; i++) begin
        fv[i] <= '0;
      end
      averaging_flag <= 1'b1;
      avg_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            vo <= in_ch.data.out_voltage;
            step <= in_ch.data.pll_phase_step;
            zc <= in_ch.data.zero_cross;
            if (averaging_flag) begin
              grid_signal_sum <= add_sat(grid_signal_sum, in_ch.data.grid_voltage);
              out_signal_sum <= add_sat(out_signal_sum, in_ch.data.out_voltage);
            end
            state <= ST_MUL_O;
          end
        end
        ST_MUL_O: begin
          grid_square_sum <= add_sat(grid_square_sum, 32'(prod >>> 38));
          state <= ST_MUL_F;
        end
        ST_MUL_F: begin
          out_square_sum <= add_sat(out_square_sum, 32'(prod >>> 38));
          state <= ST_ACC;
        end
        ST_ACC: begin
          freq_sum <= add_sat(freq_sum, fr_val);
          if (sample_counter != {COUNTER_WIDTH{1'b1}}) begin
            sample_counter <= sample_counter + 1'b1;
          end
          state <= zc ? ST_DIV_GO : ST_IDLE;
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (it_stat.done) begin
            recip <= it_result;
            job <= averaging_flag ? 3'd0 : 3'd2;
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_NORM;
        end
        ST_NORM: begin
          if ((job == 3'd2 || job == 3'd3) && norm_val <= 32'sd0) begin
            nv <= '0;
            state <= ST_OLD;
          end else begin
            nv <= norm_val;
            state <= (job == 3'd2 || job == 3'd3) ? ST_SQ_GO : ST_OLD;
          end
        end
        ST_SQ_GO: begin
          state <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (it_stat.done) begin
            nv <= {1'b0, it_result, 10'b0};
            state <= ST_OLD;
          end
        end
        ST_OLD: begin
          state <= ST_NEW;
        end
        ST_NEW: begin
          part <= 33'(prod >>> 20);
          state <= ST_SUM;
        end
        ST_SUM: begin
          fv[job] <= sat32(67'(part) + 67'(prod >>> 20));
          if (job == 3'd4) begin
            state <= ST_FIN;
          end else begin
            job <= job + 3'd1;
            state <= ST_SCALE;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            if (averaging_flag) begin
              grid_signal_sum <= '0;
              out_signal_sum <= '0;
              averaging_flag <= flag_next;
              avg_count <= flag_next ? avg_count_next : 8'd0;
            end
            grid_square_sum <= '0;
            out_square_sum <= '0;
            freq_sum <= '0;
            sample_counter <= '0;
            out_word.grid_rms <= fv[2][30:0];
            out_word.out_rms <= fv[3][30:0];
            out_word.grid_freq <= fv[4];
            out_word.grid_mean <= fv[0];
            out_word.out_mean <= fv[1];
            out_word.period_samples <= 16'(sample_counter);
            out_word.averaging_on <= flag_next;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `GPRM_ASSERT_NOW(a_done_awaited, it_stat.done, state == ST_DIV_WAIT || state == ST_SQ_WAIT)
  `GPRM_ASSERT_NOW(a_start_idle, it_req.start, !it_stat.busy)
  `GPRM_ASSERT_NOW(a_count_nonzero, state == ST_DIV_GO || state == ST_FIN, sample_counter != '0)
  `GPRM_ASSERT_NOW(a_avg_ended, !averaging_flag, avg_count == 8'd0)
  `GPRM_ASSERT_NEXT(a_accept_start, in_ch.valid && in_ch.ready, state == ST_MUL_O)
endmodule

### sim/tb_top.sv
// Testbench for grid_period_rms_meter_top: drives samples and register writes
// and checks every result word against a model of the period RMS math.
// Depends on rtl/gprm_pkg.sv, rtl/gprm_chan_if.sv and the meter RTL.
`timescale 1ns / 1ps

class period_meter_board;
  longint coeff;
  longint avg_len;
  longint grid_sq, out_sq, freq_acc, grid_acc, out_acc;
  longint sample_cnt, period_cnt;
  longint filt[5];
  bit averaging;
  gprm_pkg::out_word_t pending_results[$];
  int fails;
  int results_seen;

  function new();
    coeff = 0;
    avg_len = 25;
    grid_sq = 0;
    out_sq = 0;
    freq_acc = 0;
    grid_acc = 0;
    out_acc = 0;
    sample_cnt = 0;
    period_cnt = 0;
    foreach (filt[i]) filt[i] = 0;
    averaging = 1;
    fails = 0;
    results_seen = 0;
  endfunction

  function longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function longint floor_root(longint v);
    logic [63:0] x, r, b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function longint smooth(longint prev, longint wo, longint nv, longint wn);
    return sat(((prev * wo) >>> 20) + ((nv * wn) >>> 20));
  endfunction

  function longint rms_of(longint sq, longint recip);
    longint ms;
    ms = sat((sq * recip) >>> 12);
    if (ms <= 0) return 0;
    return sat(floor_root(ms << 10) << 10);
  endfunction

  function void write_reg(logic [7:0] idx, logic [31:0] value);
    if (idx == gprm_pkg::REG_FREQ_COEFF) coeff = longint'(value[30:0]);
    else if (idx == gprm_pkg::REG_AVG_PERIODS) avg_len = longint'(value[7:0]);
  endfunction

  function void note_sample(gprm_pkg::in_word_t w);
    longint vg, vo, st, n, recip;
    gprm_pkg::out_word_t r;
    vg = longint'(w.grid_voltage);
    vo = longint'(w.out_voltage);
    st = longint'(w.pll_phase_step);
    grid_sq = sat(grid_sq + ((vg * vg) >>> 38));
    out_sq = sat(out_sq + ((vo * vo) >>> 38));
    freq_acc = sat(freq_acc + sat((coeff * st) >>> 25));
    if (averaging) begin
      grid_acc = sat(grid_acc + vg);
      out_acc = sat(out_acc + vo);
    end
    if (sample_cnt < 65535) sample_cnt++;
    if (!w.zero_cross) return;
    n = sample_cnt;
    recip = (64'sd1 << 20) / n;
    if (averaging) begin
      filt[3] = smooth(filt[3], 734003, sat((grid_acc * recip) >>> 20), 314572);
      filt[4] = smooth(filt[4], 734003, sat((out_acc * recip) >>> 20), 314572);
      grid_acc = 0;
      out_acc = 0;
      period_cnt = (period_cnt + 1) & 255;
      if (period_cnt == avg_len) begin
        averaging = 0;
        period_cnt = 0;
      end
    end
    filt[0] = smooth(filt[0], 209715, rms_of(grid_sq, recip), 838860);
    filt[1] = smooth(filt[1], 209715, rms_of(out_sq, recip), 838860);
    filt[2] = smooth(filt[2], 419430, sat((freq_acc * recip) >>> 10), 629145);
    grid_sq = 0;
    out_sq = 0;
    freq_acc = 0;
    sample_cnt = 0;
    r.grid_rms = filt[0][30:0];
    r.out_rms = filt[1][30:0];
    r.grid_freq = filt[2][31:0];
    r.grid_mean = filt[3][31:0];
    r.out_mean = filt[4][31:0];
    r.period_samples = n[15:0];
    r.averaging_on = averaging;
    pending_results.push_back(r);
  endfunction

  function void check_word(gprm_pkg::out_word_t got);
    gprm_pkg::out_word_t e;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("unexpected result word");
      fails++;
      return;
    end
    e = pending_results.pop_front();
    if (got.grid_rms !== e.grid_rms) begin
      $error("grid_rms exp %0d got %0d", e.grid_rms, got.grid_rms);
      fails++;
    end
    if (got.out_rms !== e.out_rms) begin
      $error("out_rms exp %0d got %0d", e.out_rms, got.out_rms);
      fails++;
    end
    if (got.grid_freq !== e.grid_freq) begin
      $error("grid_freq exp %0d got %0d", e.grid_freq, got.grid_freq);
      fails++;
    end
    if (got.grid_mean !== e.grid_mean) begin
      $error("grid_mean exp %0d got %0d", e.grid_mean, got.grid_mean);
      fails++;
    end
    if (got.out_mean !== e.out_mean) begin
      $error("out_mean exp %0d got %0d", e.out_mean, got.out_mean);
      fails++;
    end
    if (got.period_samples !== e.period_samples) begin
      $error("period_samples exp %0d got %0d", e.period_samples, got.period_samples);
      fails++;
    end
    if (got.averaging_on !== e.averaging_on) begin
      $error("averaging_on exp %0d got %0d", e.averaging_on, got.averaging_on);
      fails++;
    end
  endfunction
endclass

module tb_top;
  import gprm_pkg::*;

  logic clk;
  logic rst;
  int tx_idle;
  int rx_idle;
  int hold_trigger;
  int hold_seen;
  int hold_left;
  int cycles;
  int samples_sent;
  period_meter_board board;

  gprm_chan_if #(.word_t(in_word_t)) in_ch ();
  gprm_chan_if #(.word_t(cfg_word_t)) cfg ();
  gprm_chan_if #(.word_t(out_word_t)) out_ch ();

  grid_period_rms_meter_top uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .cfg(cfg),
    .out_ch(out_ch)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= 600;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) board.check_word(out_ch.data);
  end

  function automatic logic [31:0] pick_voltage();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      default: return $urandom_range(32'h1000_0000) - 32'h0800_0000;
    endcase
  endfunction

  task automatic send_sample(logic [31:0] vg, logic [31:0] vo, logic [31:0] st, logic zc);
    in_word_t w;
    w.grid_voltage = vg;
    w.out_voltage = vo;
    w.pll_phase_step = st;
    w.zero_cross = zc;
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    board.note_sample(w);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (board.pending_results.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_word_t c;
    c.index = idx;
    c.value = value;
    cfg.valid <= 1'b1;
    cfg.data <= c;
    do @(posedge clk); while (!cfg.ready);
    board.write_reg(idx, value);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_periods(int count, int max_len);
    int left;
    left = 0;
    repeat (count) begin
      if (left == 0) left = $urandom_range(max_len, 1);
      left--;
      send_sample(pick_voltage(), pick_voltage(), $urandom, left == 0);
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    tx_idle = 0;
    rx_idle = 0;
    hold_trigger = 0;
    hold_seen = 0;
    hold_left = 0;
    cycles = 0;
    samples_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_FREQ_COEFF, 32'hFFFF_FFFF);
    write_reg(REG_AVG_PERIODS, 32'd0);

    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1);
    send_sample(32'h0, 32'h0, 32'h0, 1'b1);
    send_sample(32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 1'b0);
    send_sample(32'h1, 32'hFFFFFFFF, 32'h1, 1'b1);
    repeat (6) send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
    send_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    repeat (4) send_sample(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    send_sample(32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
    send_sample(32'h0010_0000, 32'hFFF0_0000, 32'h0000_0400, 1'b1);
    drain_results();
    write_reg(REG_FREQ_COEFF, 32'd32768);

    tx_idle = 25;
    rx_idle = 84;
    random_periods(320, 2);
    drain_results();
    write_reg(REG_FREQ_COEFF, $urandom);

    tx_idle = 84;
    rx_idle = 25;
    random_periods(120, 3);
    hold_trigger = hold_trigger + 1;
    random_periods(200, 4);
    drain_results();
    write_reg(REG_FREQ_COEFF, 32'h7FFF_FFFF);
    write_reg(REG_AVG_PERIODS, 32'd255);

    tx_idle = 0;
    rx_idle = 0;
    random_periods(320, 8);
    drain_results();

    $display("Sent %0d samples and checked %0d result words", samples_sent,
             board.results_seen);
    $display("across averaging wrap, saturating inputs, idle mixes and a long output stall.");
    if (board.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
